// ===== src/bwts_pkg.sv =====
// Shared constants, payload types and stage interfaces of the bilinear wrap texture sampler.
package bwts_pkg;

    // image geometry
    localparam int MAX_WIDTH  = 256;
    localparam int MAX_HEIGHT = 256;
    localparam int CHANNELS   = 3;
    localparam int CH_W       = 8;
    localparam int PIX_W      = CHANNELS * CH_W;
    localparam int COL_W      = $clog2(MAX_WIDTH);
    localparam int ROW_W      = $clog2(MAX_HEIGHT);
    localparam int ADDR_W     = COL_W + ROW_W;
    localparam int MEM_DEPTH  = MAX_WIDTH * MAX_HEIGHT;

    // field and register widths
    localparam int DIM_W      = 9;
    localparam int LOAD_POS_W = 8;
    localparam int COORD_W    = 20;
    localparam int FRAC_W     = 16;
    localparam int WT_W       = 8;

    // coordinate arithmetic
    localparam int PROD_W     = DIM_W + FRAC_W + 1;       // width * 17-bit fraction
    localparam int QY_W       = COORD_W - (FRAC_W + 1);   // integer part of y above 2^17
    localparam int WQ_W       = DIM_W + 1 + QY_W;
    localparam int T_W        = PROD_W - (FRAC_W + 1);
    localparam int Y_BIAS_SH  = COL_W + QY_W - 1;         // h << this keeps dividend >= 0

    // remainder unit
    localparam int REM_W      = 20;
    localparam int REM_BITS   = 4;
    localparam int REM_STAGES = REM_W / REM_BITS;

    // blend arithmetic
    localparam int LR_W       = WT_W + CH_W;
    localparam int SUM_W      = WT_W + 1 + LR_W;

    // result queue, depth must be a power of two
    localparam int FIFO_DEPTH = 16;
    localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

    // pipeline depth from accept to queue push
    localparam int COORD_STAGES = 3;
    localparam int MEM_STAGES   = 1;
    localparam int BLEND_STAGES = 2;
    localparam int PIPE_LAT     = COORD_STAGES + REM_STAGES + MEM_STAGES + BLEND_STAGES;

    // configuration register indexes
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 2'd1;

    // operation codes
    localparam logic OP_LOAD   = 1'b0;
    localparam logic OP_SAMPLE = 1'b1;

    typedef struct packed {
        logic                         op;
        logic [LOAD_POS_W-1:0]        load_column;
        logic [LOAD_POS_W-1:0]        load_row;
        logic [CH_W-1:0]              load_channel0;
        logic [CH_W-1:0]              load_channel1;
        logic [CH_W-1:0]              load_channel2;
        logic signed [COORD_W-1:0]    coord_x;
        logic signed [COORD_W-1:0]    coord_y;
    } t_in_word;

    typedef struct packed {
        logic [CH_W-1:0] out_channel0;
        logic [CH_W-1:0] out_channel1;
        logic [CH_W-1:0] out_channel2;
    } t_out_word;

    // what rides along the remainder unit
    typedef struct packed {
        logic                  op;
        logic [COL_W-1:0]      sx;
        logic [COL_W-1:0]      sxi;
        logic [WT_W-1:0]       dx;
        logic [WT_W-1:0]       dy;
        logic [LOAD_POS_W-1:0] load_column;
        logic [LOAD_POS_W-1:0] load_row;
        logic [PIX_W-1:0]      pixel;
    } t_rem_side;

    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] waddr;
        logic [PIX_W-1:0]  wdata;
        logic [ADDR_W-1:0] raddr_00;
        logic [ADDR_W-1:0] raddr_01;
        logic [ADDR_W-1:0] raddr_10;
        logic [ADDR_W-1:0] raddr_11;
    } t_mem_req;

    typedef struct packed {
        logic [PIX_W-1:0] p00;
        logic [PIX_W-1:0] p01;
        logic [PIX_W-1:0] p10;
        logic [PIX_W-1:0] p11;
    } t_quad;

endpackage

// ===== src/bilinear_wrap_texture_sampler.sv =====
// Top level of the bilinear wrap texture sampler: config, pipeline, image store and result queue.
//
//  channel | direction | handshake              | word
//  --------+-----------+------------------------+----------------------------------
//  in      | to block  | i_in_valid / o_in_stall | t_in_word: pixel load or sample
//  out     | from block| o_out_valid / i_out_stall | t_out_word: three blended channels
//  cfg     | to block  | i_cfg_valid / o_cfg_ready | index + data: image width, height
//
//  One word per cycle sustained while o_in_stall is low, loads and samples mixed freely.
//  A sample's result passes 3 coordinate stages, 5 remainder stages for the y wrap,
//  a registered image read, 2 blend stages and the result queue.
//  Reset is synchronous; the image store has no clearing pass and holds garbage
//  until pixels are loaded. Width and height reset to 256.
//  The pipeline never stalls. A credit count of samples in flight plus queued
//  results raises o_in_stall once the 16-entry result queue could fill.
module bilinear_wrap_texture_sampler (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  bwts_pkg::t_in_word                i_in_word,
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output bwts_pkg::t_out_word               o_out_word,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [bwts_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [bwts_pkg::DIM_W-1:0]        i_cfg_data
);
    import bwts_pkg::*;

    // clamped image size, 1..MAX
    logic [DIM_W-1:0]      r_width;
    logic [DIM_W-1:0]      r_height;
    // samples accepted whose result has not yet left
    logic [FIFO_CNT_W-1:0] r_inflight;
    logic [FIFO_CNT_W-1:0] n_inflight;
    // memory stage sideband
    logic                  r_m_valid;
    logic [WT_W-1:0]       r_m_dx;
    logic [WT_W-1:0]       r_m_dy;

    logic                  w_in_acc;
    logic                  w_s_acc;
    logic                  w_out_acc;
    logic                  w_c_valid;
    logic [REM_W-1:0]      w_c_dividend;
    t_rem_side             w_c_side;
    logic                  w_r_valid;
    logic [ROW_W-1:0]      w_sy;
    t_rem_side             w_r_side;
    logic [DIM_W-1:0]      w_sy_inc;
    logic [ROW_W-1:0]      w_syi;
    logic                  w_load_in_range;
    t_mem_req              w_mem_req;
    t_quad                 w_quad;
    logic                  w_push;
    t_out_word             w_push_word;

    function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v,
                                                   input logic [DIM_W-1:0] maxv);
        if (v == '0) begin
            return DIM_W'(1);
        end
        return (v > maxv) ? maxv : v;
    endfunction

    // handshakes
    assign o_cfg_ready = 1'b1;
    assign o_in_stall  = (r_inflight == FIFO_CNT_W'(FIFO_DEPTH));
    assign w_in_acc    = i_in_valid && !o_in_stall;
    assign w_s_acc     = w_in_acc && (i_in_word.op == OP_SAMPLE);
    assign w_out_acc   = o_out_valid && !i_out_stall;
    assign n_inflight  = r_inflight + FIFO_CNT_W'(w_s_acc) - FIFO_CNT_W'(w_out_acc);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width    <= DIM_W'(MAX_WIDTH);
            r_height   <= DIM_W'(MAX_HEIGHT);
            r_inflight <= '0;
        end else begin
            r_inflight <= n_inflight;
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    CFG_IMAGE_WIDTH: begin
                        r_width <= clamp_dim(i_cfg_data, DIM_W'(MAX_WIDTH));
                    end
                    CFG_IMAGE_HEIGHT: begin
                        r_height <= clamp_dim(i_cfg_data, DIM_W'(MAX_HEIGHT));
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

    // loads ride the same pipeline as samples, so a load writes the store in the
    // same stage where later samples read it: no read-after-write hazard
    bwts_coord u_coord (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (w_in_acc),
        .i_word     (i_in_word),
        .i_width    (r_width),
        .i_height   (r_height),
        .o_valid    (w_c_valid),
        .o_dividend (w_c_dividend),
        .o_side     (w_c_side)
    );

    bwts_rem u_rem (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (w_c_valid),
        .i_dividend (w_c_dividend),
        .i_divisor  (r_height),
        .i_side     (w_c_side),
        .o_valid    (w_r_valid),
        .o_rem      (w_sy),
        .o_side     (w_r_side)
    );

    // next row with wrap
    assign w_sy_inc = DIM_W'(w_sy) + DIM_W'(1);
    assign w_syi    = (w_sy_inc == r_height) ? '0 : w_sy_inc[ROW_W-1:0];

    assign w_load_in_range = (32'(w_r_side.load_column) < MAX_WIDTH)
                          && (32'(w_r_side.load_row) < MAX_HEIGHT);

    assign w_mem_req.we       = w_r_valid && (w_r_side.op == OP_LOAD) && w_load_in_range;
    assign w_mem_req.waddr    = {w_r_side.load_row[ROW_W-1:0], w_r_side.load_column[COL_W-1:0]};
    assign w_mem_req.wdata    = w_r_side.pixel;
    assign w_mem_req.raddr_00 = {w_sy,  w_r_side.sx};
    assign w_mem_req.raddr_01 = {w_syi, w_r_side.sx};
    assign w_mem_req.raddr_10 = {w_sy,  w_r_side.sxi};
    assign w_mem_req.raddr_11 = {w_syi, w_r_side.sxi};

    bwts_image_mem u_image_mem (
        .i_clk  (i_clk),
        .i_req  (w_mem_req),
        .o_quad (w_quad)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else begin
            r_m_valid <= w_r_valid && (w_r_side.op == OP_SAMPLE);
        end
    end

    always_ff @(posedge i_clk) begin
        r_m_dx <= w_r_side.dx;
        r_m_dy <= w_r_side.dy;
    end

    bwts_blend u_blend (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_m_valid),
        .i_quad  (w_quad),
        .i_dx    (r_m_dx),
        .i_dy    (r_m_dy),
        .o_valid (w_push),
        .o_word  (w_push_word)
    );

    bwts_out_fifo u_out_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_word  (w_push_word),
        .i_stall (i_out_stall),
        .o_valid (o_out_valid),
        .o_word  (o_out_word)
    );

    // credit count never passes the queue depth
    a_inflight_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_inflight <= FIFO_CNT_W'(FIFO_DEPTH))
        else $error("in-flight sample count above queue depth");

    // a waiting result is always covered by a credit
    a_out_has_credit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (r_inflight != '0))
        else $error("result offered with no sample in flight");

    // every accepted sample reaches the queue after the fixed pipeline depth
    a_sample_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_s_acc |-> ##PIPE_LAT w_push)
        else $error("sample did not reach the result queue on time");

    // a load never produces a result
    a_load_no_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_acc && (i_in_word.op == OP_LOAD)) |-> ##PIPE_LAT !w_push)
        else $error("load produced a result");

endmodule

// ===== src/bwts_coord.sv =====
// Coordinate front end: pixel-space mapping, x wrap, weights and the y dividend.
module bwts_coord (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    input  bwts_pkg::t_in_word             i_word,
    input  logic [bwts_pkg::DIM_W-1:0]     i_width,
    input  logic [bwts_pkg::DIM_W-1:0]     i_height,
    output logic                           o_valid,
    output logic [bwts_pkg::REM_W-1:0]     o_dividend,
    output bwts_pkg::t_rem_side            o_side
);
    import bwts_pkg::*;

    // stage A
    logic                     r_a_valid;
    logic                     r_a_op;
    logic [LOAD_POS_W-1:0]    r_a_col;
    logic [LOAD_POS_W-1:0]    r_a_row;
    logic [PIX_W-1:0]         r_a_pix;
    logic [PROD_W-1:0]        r_a_px;
    logic [PROD_W-1:0]        r_a_py;
    logic signed [QY_W-1:0]   r_a_qy;
    // stage B
    logic                     r_b_valid;
    logic                     r_b_op;
    logic [LOAD_POS_W-1:0]    r_b_col;
    logic [LOAD_POS_W-1:0]    r_b_row;
    logic [PIX_W-1:0]         r_b_pix;
    logic [COL_W-1:0]         r_b_sx;
    logic [WT_W-1:0]          r_b_dx;
    logic [WT_W-1:0]          r_b_dy;
    logic [T_W-1:0]           r_b_t;
    logic signed [WQ_W-1:0]   r_b_wq;
    // stage C
    logic                     r_c_valid;
    logic [REM_W-1:0]         r_c_dividend;
    t_rem_side                r_c_side;

    logic [FRAC_W:0]          w_rx;
    logic [FRAC_W:0]          w_ry;
    logic [PROD_W-1:0]        w_px;
    logic [PROD_W-1:0]        w_py;
    logic [PROD_W-1:0]        w_sy_sum;
    logic signed [WQ_W-1:0]   w_wq;
    logic signed [REM_W:0]    w_vp;
    logic [DIM_W-1:0]         w_sx_inc;
    logic [COL_W-1:0]         w_sxi;

    // x*W + W*2^16 = W*(x + 2^16): only the low 17 bits of x + 2^16 matter mod W
    assign w_rx = {~i_word.coord_x[FRAC_W], i_word.coord_x[FRAC_W-1:0]};
    assign w_ry = i_word.coord_y[FRAC_W:0];
    assign w_px = PROD_W'(i_width) * PROD_W'(w_rx);
    assign w_py = PROD_W'(i_width) * PROD_W'(w_ry);

    assign w_sy_sum = r_a_py + (PROD_W'(i_height) << FRAC_W);
    assign w_wq     = $signed({1'b0, i_width}) * r_a_qy;

    assign w_vp = (REM_W+1)'(r_b_wq)
                + $signed((REM_W+1)'(r_b_t))
                + $signed((REM_W+1)'(i_height) << Y_BIAS_SH);

    assign w_sx_inc = DIM_W'(r_b_sx) + DIM_W'(1);
    assign w_sxi    = (w_sx_inc == i_width) ? '0 : w_sx_inc[COL_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_b_valid <= 1'b0;
            r_c_valid <= 1'b0;
        end else begin
            r_a_valid <= i_valid;
            r_b_valid <= r_a_valid;
            r_c_valid <= r_b_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_a_op  <= i_word.op;
        r_a_col <= i_word.load_column;
        r_a_row <= i_word.load_row;
        r_a_pix <= {i_word.load_channel2, i_word.load_channel1, i_word.load_channel0};
        r_a_px  <= w_px;
        r_a_py  <= w_py;
        r_a_qy  <= i_word.coord_y[COORD_W-1:FRAC_W+1];

        r_b_op  <= r_a_op;
        r_b_col <= r_a_col;
        r_b_row <= r_a_row;
        r_b_pix <= r_a_pix;
        r_b_sx  <= r_a_px[FRAC_W+COL_W:FRAC_W+1];
        r_b_dx  <= r_a_px[FRAC_W:FRAC_W-WT_W+1];
        r_b_t   <= w_sy_sum[PROD_W-1:FRAC_W+1];
        r_b_dy  <= w_sy_sum[FRAC_W:FRAC_W-WT_W+1];
        r_b_wq  <= w_wq;

        r_c_dividend         <= w_vp[REM_W-1:0];
        r_c_side.op          <= r_b_op;
        r_c_side.sx          <= r_b_sx;
        r_c_side.sxi         <= w_sxi;
        r_c_side.dx          <= r_b_dx;
        r_c_side.dy          <= r_b_dy;
        r_c_side.load_column <= r_b_col;
        r_c_side.load_row    <= r_b_row;
        r_c_side.pixel       <= r_b_pix;
    end

    assign o_valid    = r_c_valid;
    assign o_dividend = r_c_dividend;
    assign o_side     = r_c_side;

endmodule

// ===== src/bwts_rem.sv =====
// Pipelined restoring remainder unit for the y wrap, a few dividend bits per stage.
module bwts_rem (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    input  logic [bwts_pkg::REM_W-1:0]     i_dividend,
    input  logic [bwts_pkg::DIM_W-1:0]     i_divisor,
    input  bwts_pkg::t_rem_side            i_side,
    output logic                           o_valid,
    output logic [bwts_pkg::ROW_W-1:0]     o_rem,
    output bwts_pkg::t_rem_side            o_side
);
    import bwts_pkg::*;

    logic             r_valid [REM_STAGES];
    logic [ROW_W-1:0] r_rem   [REM_STAGES];
    t_rem_side        r_side  [REM_STAGES];
    logic [REM_W-1:0] r_dvd   [REM_STAGES-1];

    // remainder stays below the divisor, so it fits ROW_W bits
    function automatic logic [ROW_W-1:0] rem_steps(input logic [ROW_W-1:0] rem_in,
                                                   input logic [REM_BITS-1:0] bits,
                                                   input logic [DIM_W-1:0] divisor);
        logic [ROW_W:0]   acc;
        logic [ROW_W-1:0] rem;
        rem = rem_in;
        for (int i = REM_BITS - 1; i >= 0; i--) begin
            acc = {rem, bits[i]};
            if (DIM_W'(acc) >= divisor) begin
                acc = acc - (ROW_W+1)'(divisor);
            end
            rem = acc[ROW_W-1:0];
        end
        return rem;
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s < REM_STAGES; s++) begin
                r_valid[s] <= 1'b0;
            end
        end else begin
            r_valid[0] <= i_valid;
            for (int s = 1; s < REM_STAGES; s++) begin
                r_valid[s] <= r_valid[s-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_rem[0]  <= rem_steps('0, i_dividend[REM_W-1 -: REM_BITS], i_divisor);
        r_side[0] <= i_side;
        r_dvd[0]  <= i_dividend << REM_BITS;
        for (int s = 1; s < REM_STAGES; s++) begin
            r_rem[s]  <= rem_steps(r_rem[s-1], r_dvd[s-1][REM_W-1 -: REM_BITS], i_divisor);
            r_side[s] <= r_side[s-1];
        end
        for (int s = 1; s < REM_STAGES - 1; s++) begin
            r_dvd[s] <= r_dvd[s-1] << REM_BITS;
        end
    end

    assign o_valid = r_valid[REM_STAGES-1];
    assign o_rem   = r_rem[REM_STAGES-1];
    assign o_side  = r_side[REM_STAGES-1];

endmodule

// ===== src/bwts_image_mem.sv =====
// Image store: two full copies, each one write port and two registered read ports.
module bwts_image_mem (
    input  logic                 i_clk,
    input  bwts_pkg::t_mem_req   i_req,
    output bwts_pkg::t_quad      o_quad
);
    import bwts_pkg::*;

    // copy A serves the current row, copy B the next row
    logic [PIX_W-1:0] r_mem_a [MEM_DEPTH];
    logic [PIX_W-1:0] r_mem_b [MEM_DEPTH];
    logic [PIX_W-1:0] r_rd_00;
    logic [PIX_W-1:0] r_rd_10;
    logic [PIX_W-1:0] r_rd_01;
    logic [PIX_W-1:0] r_rd_11;

    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem_a[i_req.waddr] <= i_req.wdata;
        end
        r_rd_00 <= r_mem_a[i_req.raddr_00];
        r_rd_10 <= r_mem_a[i_req.raddr_10];
    end

    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem_b[i_req.waddr] <= i_req.wdata;
        end
        r_rd_01 <= r_mem_b[i_req.raddr_01];
        r_rd_11 <= r_mem_b[i_req.raddr_11];
    end

    assign o_quad.p00 = r_rd_00;
    assign o_quad.p01 = r_rd_01;
    assign o_quad.p10 = r_rd_10;
    assign o_quad.p11 = r_rd_11;

endmodule

// ===== src/bwts_blend.sv =====
// Two-stage bilinear blend of the four neighbors, all channels in parallel.
module bwts_blend (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    input  bwts_pkg::t_quad            i_quad,
    input  logic [bwts_pkg::WT_W-1:0]  i_dx,
    input  logic [bwts_pkg::WT_W-1:0]  i_dy,
    output logic                       o_valid,
    output bwts_pkg::t_out_word        o_word
);
    import bwts_pkg::*;

    localparam int WT_ONE = 1 << WT_W;

    logic            r_valid1;
    logic            r_valid2;
    logic [WT_W-1:0] r_dx;
    logic [LR_W-1:0] r_left  [CHANNELS];
    logic [LR_W-1:0] r_right [CHANNELS];
    logic [CH_W-1:0] r_out   [CHANNELS];

    logic [WT_W:0]    w_wdy;
    logic [WT_W:0]    w_wdx;
    logic [LR_W-1:0]  w_left  [CHANNELS];
    logic [LR_W-1:0]  w_right [CHANNELS];
    logic [SUM_W-1:0] w_sum   [CHANNELS];

    function automatic logic [CH_W-1:0] pix_ch(input logic [PIX_W-1:0] pix, input int c);
        return pix[c*CH_W +: CH_W];
    endfunction

    assign w_wdy = (WT_W+1)'(WT_ONE) - (WT_W+1)'(i_dy);
    assign w_wdx = (WT_W+1)'(WT_ONE) - (WT_W+1)'(r_dx);

    always_comb begin
        for (int c = 0; c < CHANNELS; c++) begin
            w_left[c]  = LR_W'((LR_W+1)'(w_wdy) * (LR_W+1)'(pix_ch(i_quad.p00, c))
                             + (LR_W+1)'(i_dy) * (LR_W+1)'(pix_ch(i_quad.p01, c)));
            w_right[c] = LR_W'((LR_W+1)'(w_wdy) * (LR_W+1)'(pix_ch(i_quad.p10, c))
                             + (LR_W+1)'(i_dy) * (LR_W+1)'(pix_ch(i_quad.p11, c)));
            w_sum[c]   = SUM_W'(w_wdx) * SUM_W'(r_left[c]) + SUM_W'(r_dx) * SUM_W'(r_right[c]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid1 <= 1'b0;
            r_valid2 <= 1'b0;
        end else begin
            r_valid1 <= i_valid;
            r_valid2 <= r_valid1;
        end
    end

    always_ff @(posedge i_clk) begin
        r_dx <= i_dx;
        for (int c = 0; c < CHANNELS; c++) begin
            r_left[c]  <= w_left[c];
            r_right[c] <= w_right[c];
            r_out[c]   <= w_sum[c][2*WT_W+CH_W-1:2*WT_W];
        end
    end

    assign o_valid             = r_valid2;
    assign o_word.out_channel0 = r_out[0];
    assign o_word.out_channel1 = r_out[1];
    assign o_word.out_channel2 = r_out[2];

endmodule

// ===== src/bwts_out_fifo.sv =====
// Result queue between the free-running pipeline and the output channel.
module bwts_out_fifo (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_push,
    input  bwts_pkg::t_out_word   i_word,
    input  logic                  i_stall,
    output logic                  o_valid,
    output bwts_pkg::t_out_word   o_word
);
    import bwts_pkg::*;

    t_out_word             r_mem [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0] r_wr_ptr;
    logic [FIFO_PTR_W-1:0] r_rd_ptr;
    logic [FIFO_CNT_W-1:0] r_count;
    logic                  w_pop;

    assign o_valid = (r_count != '0);
    assign o_word  = r_mem[r_rd_ptr];
    assign w_pop   = o_valid && !i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + FIFO_PTR_W'(1);
            end
            if (w_pop) begin
                r_rd_ptr <= r_rd_ptr + FIFO_PTR_W'(1);
            end
            r_count <= r_count + FIFO_CNT_W'(i_push) - FIFO_CNT_W'(w_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_word;
        end
    end

endmodule
